[rtl/lj_pair_force_energy_macros.svh]
// Assertion macros for the Lennard-Jones pair kernel.
// Used by the top level; expects clk and rst_n in scope.
`ifndef LJ_PAIR_FORCE_ENERGY_MACROS_SVH
`define LJ_PAIR_FORCE_ENERGY_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LJ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication with a fixed delay in clock cycles.
`define LJ_ASSERT_DELAY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
    else $error(msg);

`endif

[rtl/ljpf_pkg.sv]
// Shared constants, types and arithmetic helpers of the Lennard-Jones pair kernel.
// No dependencies; imported by lj_pair_force_energy.
package ljpf_pkg;

  // Coordinate width and the widths that follow from it in the wrap stages.
  localparam int COORD_BITS = 24;
  localparam int KW         = COORD_BITS - 16;
  localparam int SHW        = KW + 24;
  localparam int TW         = SHW + 1;
  localparam int AW         = 31;
  localparam int R2W        = 48;
  localparam int DIV_STEPS  = 64;

  // Configuration register indexes.
  localparam logic [2:0] CFG_BOX_X     = 3'd0;
  localparam logic [2:0] CFG_BOX_Y     = 3'd1;
  localparam logic [2:0] CFG_BOX_Z     = 3'd2;
  localparam logic [2:0] CFG_INV_HALF  = 3'd3;
  localparam logic [2:0] CFG_CUTOFF_SQ = 3'd4;
  localparam logic [2:0] CFG_SIGMA_SQ  = 3'd5;
  localparam logic [2:0] CFG_EPSILON   = 3'd6;

  // Fixed-point constants.
  localparam logic [63:0]   ONE_Q24   = 64'd16777216;
  localparam logic [63:0]   HALF_Q24  = 64'd8388608;
  localparam logic [63:0]   NEG_LIM48 = 64'h0000_8000_0000_0000;
  localparam logic [47:0]   MAX_POS48 = 48'h7FFF_FFFF_FFFF;
  localparam logic [AW-1:0] DIFF_MAX  = '1;
  localparam logic [63:0]   INV_NUM   = 64'h0100_0000_0000_0000;

  // Four 32x32 partial products of a 64x64 multiply.
  typedef struct packed {
    logic [63:0] p11;
    logic [63:0] p10;
    logic [63:0] p01;
    logic [63:0] p00;
  } pp_t;

  // Shifted product with its overflow flag.
  typedef struct packed {
    logic        sat;
    logic [63:0] val;
  } mres_t;

  // Clipped 48-bit output with its flag.
  typedef struct packed {
    logic        sat;
    logic [47:0] val;
  } cres_t;

  // One divider lane: partial remainder and numerator/quotient shift word.
  typedef struct packed {
    logic [R2W-1:0] rem;
    logic [63:0]    nq;
  } dstep_t;

  // Partial products, one 32x32 multiplier each.
  function automatic pp_t mul_pp(input logic [63:0] a, input logic [63:0] b);
    pp_t p;
    p.p00 = a[31:0] * b[31:0];
    p.p01 = a[31:0] * b[63:32];
    p.p10 = a[63:32] * b[31:0];
    p.p11 = a[63:32] * b[63:32];
    return p;
  endfunction

  // Sum the partial products, shift right and hold at all ones on overflow.
  function automatic mres_t mul_fin(input pp_t p, input logic [5:0] sh);
    logic [127:0] full;
    mres_t        r;
    full  = {p.p11, 64'b0} + {32'b0, p.p01, 32'b0} + {32'b0, p.p10, 32'b0}
          + {64'b0, p.p00};
    r.sat = (full[127:64] >> sh) != 64'b0;
    r.val = r.sat ? '1 : 64'(full >> sh);
    return r;
  endfunction

  // Sign and magnitude to a clipped 48-bit two's complement value.
  function automatic cres_t clip48(input logic [63:0] mag, input logic neg);
    cres_t       r;
    logic [63:0] m;
    if (!neg) begin
      r.sat = mag > {16'b0, MAX_POS48};
      r.val = r.sat ? MAX_POS48 : mag[47:0];
    end else begin
      r.sat = mag > NEG_LIM48;
      m     = r.sat ? NEG_LIM48 : mag;
      r.val = 48'(~m + 64'd1);
    end
    return r;
  endfunction

  // One restoring division step: one quotient bit.
  function automatic dstep_t div_step(input dstep_t s, input logic [R2W-1:0] d);
    logic [R2W:0] t;
    logic         ge;
    dstep_t       r;
    t     = {s.rem, s.nq[63]};
    ge    = t >= {1'b0, d};
    r.rem = ge ? R2W'(t - {1'b0, d}) : t[R2W-1:0];
    r.nq  = {s.nq[62:0], ge};
    return r;
  endfunction

endpackage

[rtl/lj_pair_force_energy.sv]
// Lennard-Jones 12-6 pair force and energy kernel, fully pipelined.
// Depends on ljpf_pkg and lj_pair_force_energy_macros.svh.

// The block takes one particle pair in every clock cycle and never raises
// busy; each result appears on the out_ ports for one cycle with out_valid
// high, in the order the pairs came in. The receiver cannot stall the
// block, so results must be taken as they come. The latency is set mainly
// by the two radix-2 dividers (sigma^2/r2 and 1/r2), which run side by side
// as a 64-stage pipeline, one quotient bit per stage; six wrap and distance
// stages come before them and fourteen multiply and output stages after.
// Configuration writes take effect at once and are only to be made while no
// pairs are in flight.
`include "lj_pair_force_energy_macros.svh"

module lj_pair_force_energy import ljpf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] in_pos_ix,
  input  logic [COORD_BITS-1:0] in_pos_iy,
  input  logic [COORD_BITS-1:0] in_pos_iz,
  input  logic [COORD_BITS-1:0] in_pos_jx,
  input  logic [COORD_BITS-1:0] in_pos_jy,
  input  logic [COORD_BITS-1:0] in_pos_jz,
  input  logic                  in_kind_i,
  input  logic                  in_kind_j,
  input  logic                  in_same_particle,
  output logic                  out_valid,
  output logic signed [47:0]    out_grad_x,
  output logic signed [47:0]    out_grad_y,
  output logic signed [47:0]    out_grad_z,
  output logic signed [47:0]    out_pair_energy,
  output logic                  out_within_cutoff,
  output logic                  out_saturated,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [63:0]           cfg_wdata
);

  localparam int NPRE  = 5;
  localparam int NPOST = 13;
  localparam int LAT   = NPRE + 1 + DIV_STEPS + NPOST + 1;

  typedef struct packed {
    logic                       valid;
    logic                       same;
    logic [15:0]                s2;
    logic [15:0]                eps;
    logic [2:0]                 dneg;
    logic [2:0][COORD_BITS-1:0] mag;
    logic [2:0][KW-1:0]         k;
    logic [2:0][TW-1:0]         t;
    logic [2:0][AW-1:0]         ad;
    logic [2:0][2*AW-1:0]       sq;
  } pre_t;

  typedef struct packed {
    logic                valid;
    logic                inr;
    logic [2:0]          dneg;
    logic [2:0][AW-1:0]  ad;
    logic [15:0]         eps;
    logic [R2W-1:0]      r2;
    dstep_t              q1;
    dstep_t              q2;
  } div_t;

  typedef struct packed {
    logic               valid;
    logic               inr;
    logic               sat;
    logic [2:0]         dneg;
    logic [2:0][AW-1:0] ad;
    logic [15:0]        eps;
    logic [63:0]        sr2;
    logic [63:0]        invr2;
    logic [63:0]        sr4;
    logic [63:0]        sr6;
    logic               eneg;
    logic               fneg;
    logic [63:0]        emag;
    logic [63:0]        fmag;
    logic [63:0]        e1;
    logic [63:0]        m;
    logic [63:0]        e2;
    logic [63:0]        w;
    logic [63:0]        g;
    logic [2:0][63:0]   f;
    pp_t [2:0]          pp;
  } post_t;

  // Configuration registers.
  logic [23:0] box_r [3];
  logic [59:0] inv_half_box_r;
  logic [31:0] cutoff_sq_r;
  logic [63:0] sigma_sq_table_r;
  logic [63:0] epsilon_table_r;

  pre_t  pre_r  [NPRE];
  pre_t  pre_nxt[NPRE];
  div_t  dv_r   [DIV_STEPS+1];
  div_t  dv_nxt [DIV_STEPS+1];
  post_t post_r [NPOST];
  post_t post_nxt[NPOST];

  logic               out_valid_r, out_valid_nxt;
  logic [47:0]        grad_r [3];
  logic [47:0]        grad_nxt [3];
  logic [47:0]        energy_r, energy_nxt;
  logic               within_r, within_nxt;
  logic               sat_r, sat_nxt;

  logic [COORD_BITS-1:0] pos_i [3];
  logic [COORD_BITS-1:0] pos_j [3];

  // The pipeline never stalls, so a pair is taken in every cycle.
  assign busy = 1'b0;

  assign pos_i[0] = in_pos_ix;
  assign pos_i[1] = in_pos_iy;
  assign pos_i[2] = in_pos_iz;
  assign pos_j[0] = in_pos_jx;
  assign pos_j[1] = in_pos_jy;
  assign pos_j[2] = in_pos_jz;

  // Table lookup, difference, wrap, clamp and square stages in front of the dividers.
  always_comb begin
    logic [COORD_BITS+19:0] prod;
    logic [SHW-1:0]         shv;
    logic                   tneg;
    logic [TW-1:0]          tabs;
    logic [1:0]             idx;

    // Stage 0: table lookup and signed axis differences.
    pre_nxt[0]       = '0;
    idx              = {in_kind_i, in_kind_j};
    pre_nxt[0].valid = start;
    pre_nxt[0].same  = in_same_particle;
    pre_nxt[0].s2    = sigma_sq_table_r[16*idx +: 16];
    pre_nxt[0].eps   = epsilon_table_r[16*idx +: 16];
    for (int a = 0; a < 3; a++) begin
      pre_nxt[0].dneg[a] = pos_i[a] < pos_j[a];
      pre_nxt[0].mag[a]  = pre_nxt[0].dneg[a] ? pos_j[a] - pos_i[a]
                                              : pos_i[a] - pos_j[a];
    end

    // Stage 1: number of box lengths to take off each axis.
    pre_nxt[1] = pre_r[0];
    for (int a = 0; a < 3; a++) begin
      prod              = pre_r[0].mag[a] * inv_half_box_r[20*a +: 20];
      pre_nxt[1].k[a]   = prod[COORD_BITS+19:36];
    end

    // Stage 2: wrapped magnitude, possibly crossing zero.
    pre_nxt[2] = pre_r[1];
    for (int a = 0; a < 3; a++) begin
      shv             = pre_r[1].k[a] * box_r[a];
      pre_nxt[2].t[a] = TW'(pre_r[1].mag[a]) - TW'(shv);
    end

    // Stage 3: absolute value, sign fix-up and clamp.
    pre_nxt[3] = pre_r[2];
    for (int a = 0; a < 3; a++) begin
      tneg                = pre_r[2].t[a][TW-1];
      tabs                = tneg ? TW'(-pre_r[2].t[a]) : pre_r[2].t[a];
      pre_nxt[3].ad[a]    = (tabs > TW'(DIFF_MAX)) ? DIFF_MAX : tabs[AW-1:0];
      pre_nxt[3].dneg[a]  = pre_r[2].dneg[a] ^ tneg;
    end

    // Stage 4: squares.
    pre_nxt[4] = pre_r[3];
    for (int a = 0; a < 3; a++) begin
      pre_nxt[4].sq[a] = pre_r[3].ad[a] * pre_r[3].ad[a];
    end
  end

  // Divider entry, then one quotient bit per stage for both quotients.
  always_comb begin
    logic [63:0] r2f;

    // Squared distance, cutoff test and numerators.
    r2f = 64'(pre_r[4].sq[0]) + 64'(pre_r[4].sq[1]) + 64'(pre_r[4].sq[2]);
    dv_nxt[0]       = '0;
    dv_nxt[0].valid = pre_r[4].valid;
    dv_nxt[0].inr   = !pre_r[4].same && (r2f < {16'b0, cutoff_sq_r, 16'b0});
    dv_nxt[0].dneg  = pre_r[4].dneg;
    dv_nxt[0].ad    = pre_r[4].ad;
    dv_nxt[0].eps   = pre_r[4].eps;
    dv_nxt[0].r2    = (r2f[R2W-1:0] == '0) ? R2W'(1) : r2f[R2W-1:0];
    dv_nxt[0].q1.nq = {pre_r[4].s2, 48'b0};
    dv_nxt[0].q2.nq = INV_NUM;

    for (int i = 1; i <= DIV_STEPS; i++) begin
      dv_nxt[i]    = dv_r[i-1];
      dv_nxt[i].q1 = div_step(dv_r[i-1].q1, dv_r[i-1].r2);
      dv_nxt[i].q2 = div_step(dv_r[i-1].q2, dv_r[i-1].r2);
    end
  end

  // Multiply stages: partial products, then sum, shift and saturate.
  always_comb begin
    mres_t mr_sr4, mr_sr6, mr_e1, mr_m, mr_e2, mr_w, mr_g;
    mres_t mr_f [3];

    post_nxt[0]       = '0;
    post_nxt[0].valid = dv_r[DIV_STEPS].valid;
    post_nxt[0].inr   = dv_r[DIV_STEPS].inr;
    post_nxt[0].dneg  = dv_r[DIV_STEPS].dneg;
    post_nxt[0].ad    = dv_r[DIV_STEPS].ad;
    post_nxt[0].eps   = dv_r[DIV_STEPS].eps;
    post_nxt[0].sr2   = dv_r[DIV_STEPS].q1.nq;
    post_nxt[0].invr2 = dv_r[DIV_STEPS].q2.nq;
    post_nxt[0].pp[0] = mul_pp(dv_r[DIV_STEPS].q1.nq, dv_r[DIV_STEPS].q1.nq);

    // sr4 = sr2 * sr2
    post_nxt[1]     = post_r[0];
    mr_sr4          = mul_fin(post_r[0].pp[0], 6'd24);
    post_nxt[1].sr4 = mr_sr4.val;
    post_nxt[1].sat = post_r[0].sat | mr_sr4.sat;

    post_nxt[2]       = post_r[1];
    post_nxt[2].pp[0] = mul_pp(post_r[1].sr4, post_r[1].sr2);

    // sr6 = sr4 * sr2
    post_nxt[3]     = post_r[2];
    mr_sr6          = mul_fin(post_r[2].pp[0], 6'd24);
    post_nxt[3].sr6 = mr_sr6.val;
    post_nxt[3].sat = post_r[2].sat | mr_sr6.sat;

    // Signs and magnitudes of (sr6 - 1) and (0.5 - sr6).
    post_nxt[4]      = post_r[3];
    post_nxt[4].eneg = post_r[3].sr6 < ONE_Q24;
    post_nxt[4].emag = post_nxt[4].eneg ? ONE_Q24 - post_r[3].sr6
                                        : post_r[3].sr6 - ONE_Q24;
    post_nxt[4].fneg = post_r[3].sr6 > HALF_Q24;
    post_nxt[4].fmag = post_nxt[4].fneg ? post_r[3].sr6 - HALF_Q24
                                        : HALF_Q24 - post_r[3].sr6;

    post_nxt[5]       = post_r[4];
    post_nxt[5].pp[0] = mul_pp(post_r[4].sr6, post_r[4].emag);
    post_nxt[5].pp[1] = mul_pp(post_r[4].sr6, post_r[4].fmag);

    post_nxt[6]     = post_r[5];
    mr_e1           = mul_fin(post_r[5].pp[0], 6'd24);
    mr_m            = mul_fin(post_r[5].pp[1], 6'd24);
    post_nxt[6].e1  = mr_e1.val;
    post_nxt[6].m   = mr_m.val;
    post_nxt[6].sat = post_r[5].sat | mr_e1.sat | mr_m.sat;

    post_nxt[7]       = post_r[6];
    post_nxt[7].pp[0] = mul_pp(post_r[6].e1, 64'(post_r[6].eps));
    post_nxt[7].pp[1] = mul_pp(post_r[6].m, post_r[6].invr2);

    post_nxt[8]     = post_r[7];
    mr_e2           = mul_fin(post_r[7].pp[0], 6'd8);
    mr_w            = mul_fin(post_r[7].pp[1], 6'd24);
    post_nxt[8].e2  = mr_e2.val;
    post_nxt[8].w   = mr_w.val;
    post_nxt[8].sat = post_r[7].sat | mr_e2.sat | mr_w.sat;

    // g = w * 48 * eps
    post_nxt[9]       = post_r[8];
    post_nxt[9].pp[1] = mul_pp(post_r[8].w, 64'(post_r[8].eps) * 64'd48);

    post_nxt[10]     = post_r[9];
    mr_g             = mul_fin(post_r[9].pp[1], 6'd8);
    post_nxt[10].g   = mr_g.val;
    post_nxt[10].sat = post_r[9].sat | mr_g.sat;

    // Per-axis force terms.
    post_nxt[11] = post_r[10];
    for (int a = 0; a < 3; a++) begin
      post_nxt[11].pp[a] = mul_pp(post_r[10].g, 64'(post_r[10].ad[a]));
    end

    post_nxt[12] = post_r[11];
    for (int a = 0; a < 3; a++) begin
      mr_f[a]             = mul_fin(post_r[11].pp[a], 6'd16);
      post_nxt[12].f[a]   = mr_f[a].val;
    end
    post_nxt[12].sat = post_r[11].sat | mr_f[0].sat | mr_f[1].sat | mr_f[2].sat;
  end

  // Output stage: clip to 48 bits and zero pairs that do not interact.
  always_comb begin
    cres_t ce;
    cres_t cf [3];
    logic  go;
    go = post_r[NPOST-1].valid & post_r[NPOST-1].inr;
    ce = clip48(post_r[NPOST-1].e2,
                post_r[NPOST-1].eneg && (post_r[NPOST-1].e2 != 64'b0));
    for (int a = 0; a < 3; a++) begin
      cf[a]       = clip48(post_r[NPOST-1].f[a],
                           (post_r[NPOST-1].fneg != post_r[NPOST-1].dneg[a]) &&
                           (post_r[NPOST-1].f[a] != 64'b0));
      grad_nxt[a] = go ? cf[a].val : 48'b0;
    end
    energy_nxt    = go ? ce.val : 48'b0;
    within_nxt    = go;
    sat_nxt       = go & (post_r[NPOST-1].sat | ce.sat | cf[0].sat | cf[1].sat |
                          cf[2].sat);
    out_valid_nxt = post_r[NPOST-1].valid;
  end

  // Configuration writes, pipeline registers and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r[0]         <= '0;
      box_r[1]         <= '0;
      box_r[2]         <= '0;
      inv_half_box_r   <= '0;
      cutoff_sq_r      <= '0;
      sigma_sq_table_r <= '0;
      epsilon_table_r  <= '0;
      out_valid_r      <= 1'b0;
      within_r         <= 1'b0;
      sat_r            <= 1'b0;
      for (int k = 0; k < NPRE; k++) pre_r[k].valid <= 1'b0;
      for (int k = 0; k <= DIV_STEPS; k++) dv_r[k].valid <= 1'b0;
      for (int k = 0; k < NPOST; k++) post_r[k].valid <= 1'b0;
    end else begin
      pre_r       <= pre_nxt;
      dv_r        <= dv_nxt;
      post_r      <= post_nxt;
      grad_r      <= grad_nxt;
      energy_r    <= energy_nxt;
      within_r    <= within_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BOX_X:     box_r[0]         <= cfg_wdata[23:0];
          CFG_BOX_Y:     box_r[1]         <= cfg_wdata[23:0];
          CFG_BOX_Z:     box_r[2]         <= cfg_wdata[23:0];
          CFG_INV_HALF:  inv_half_box_r   <= cfg_wdata[59:0];
          CFG_CUTOFF_SQ: cutoff_sq_r      <= cfg_wdata[31:0];
          CFG_SIGMA_SQ:  sigma_sq_table_r <= cfg_wdata;
          CFG_EPSILON:   epsilon_table_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_grad_x        = grad_r[0];
  assign out_grad_y        = grad_r[1];
  assign out_grad_z        = grad_r[2];
  assign out_pair_energy   = energy_r;
  assign out_within_cutoff = within_r;
  assign out_saturated     = sat_r;

  // A pair outside the cutoff carries no force, no energy and no flag.
  `LJ_ASSERT_IMPL(a_zero_outside, out_valid && !out_within_cutoff, out_grad_x == '0 && out_grad_y == '0 && out_grad_z == '0 && out_pair_energy == '0 && !out_saturated, "nonzero result for a pair outside the cutoff")
  // Clipping is only reported on a delivered, interacting pair.
  `LJ_ASSERT_IMPL(a_sat_inside, out_saturated, out_valid && out_within_cutoff, "saturated flag without an interacting result")
  // Every accepted pair gives its result after the fixed latency.
  `LJ_ASSERT_DELAY(a_latency, start && !busy, LAT, out_valid, "result missing after pipeline latency")

endmodule

[verif/tb_lj_pair_force_energy.sv]
// Self-checking testbench for the Lennard-Jones pair force and energy kernel.
// Depends on ljpf_pkg and lj_pair_force_energy; a built-in predictor or a typed-in row checks each result.
`timescale 1ns / 1ps

module tb_lj_pair_force_energy import ljpf_pkg::*;;

  // Index with no register behind it.
  localparam logic [2:0] CFG_SPARE = 3'd7;

  // One particle pair as it enters the block.
  typedef struct packed {
    logic [23:0] ix, iy, iz, jx, jy, jz;
    logic        ki, kj, same;
  } pair_t;

  // One force and energy result.
  typedef struct packed {
    logic [47:0] gx, gy, gz, energy;
    logic        in_range, clipped;
  } lj_result_t;

  // Directed stimulus row; a typed-in expectation is used where has_typed is set.
  typedef struct packed {
    pair_t      pair;
    logic       has_typed;
    lj_result_t typed;
  } dir_row_t;

  logic clk, rst_n, start, busy;
  logic [23:0] in_pos_ix, in_pos_iy, in_pos_iz, in_pos_jx, in_pos_jy, in_pos_jz;
  logic in_kind_i, in_kind_j, in_same_particle;
  logic out_valid, out_within_cutoff, out_saturated;
  logic signed [47:0] out_grad_x, out_grad_y, out_grad_z, out_pair_energy;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [63:0] cfg_wdata;

  // Shadow copy of the configuration registers.
  logic [23:0] box_len [3];
  logic [59:0] inv_half;
  logic [31:0] cut_sq;
  logic [63:0] sig_tab, eps_tab;

  lj_result_t force_q[$];
  dir_row_t   dir_tab[$];
  int         fails;

  lj_pair_force_energy u_top (.*);

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog on the whole run.
  initial begin
    #5ms;
    $display("tb_lj_pair_force_energy NOT OK");
    $finish;
  end

  // Product shifted right, held at all ones when it overflows 64 bits.
  function automatic logic [63:0] shr_prod(input logic [63:0] a, input logic [63:0] b,
                                           input int sh, inout logic hit);
    logic [127:0] full;
    full = {64'b0, a} * {64'b0, b};
    if ((full[127:64] >> sh) != 64'b0) begin
      hit = 1'b1;
      return '1;
    end
    return 64'(full >> sh);
  endfunction

  // Sign and magnitude to a clipped 48-bit two's complement value.
  function automatic logic [47:0] to_q48(input logic [63:0] mag, input logic neg,
                                         inout logic hit);
    logic [63:0] m;
    m = mag;
    if (!neg) begin
      if (m > 64'h7FFF_FFFF_FFFF) begin
        hit = 1'b1;
        m = 64'h7FFF_FFFF_FFFF;
      end
      return m[47:0];
    end
    if (m > 64'h8000_0000_0000) begin
      hit = 1'b1;
      m = 64'h8000_0000_0000;
    end
    return 48'(~m + 64'd1);
  endfunction

  // Minimum-image difference along one axis, held to 31 bits of magnitude.
  function automatic logic signed [63:0] wrap_diff(input logic [23:0] pi,
                                                   input logic [23:0] pj, input int ax);
    logic signed [63:0] d, k, shift;
    logic [63:0] mag, inv;
    d = $signed({40'b0, pi}) - $signed({40'b0, pj});
    inv = 64'((inv_half >> (20 * ax)) & 60'hFFFFF);
    mag = d < 0 ? 64'(-d) : 64'(d);
    k = $signed((mag * inv) >> 36);
    shift = k * $signed({40'b0, box_len[ax]});
    d = d < 0 ? d + shift : d - shift;
    if (d > 64'sd2147483647) d = 64'sd2147483647;
    if (d < -64'sd2147483647) d = -64'sd2147483647;
    return d;
  endfunction

  // Expected force terms and energy of one pair.
  function automatic lj_result_t predict_pair(input pair_t p);
    lj_result_t r;
    logic signed [63:0] d [3];
    logic [63:0] ad [3];
    logic [63:0] r2, s2, eps, sr2, sr4, sr6, mag, m, inv_r2, w, g, f;
    logic [1:0] idx;
    logic neg, hit;
    r = '0;
    hit = 1'b0;
    if (p.same) return r;
    d[0] = wrap_diff(p.ix, p.jx, 0);
    d[1] = wrap_diff(p.iy, p.jy, 1);
    d[2] = wrap_diff(p.iz, p.jz, 2);
    r2 = 64'd0;
    for (int a = 0; a < 3; a++) begin
      ad[a] = d[a] < 0 ? 64'(-d[a]) : 64'(d[a]);
      r2 += ad[a] * ad[a];
    end
    if (r2 >= ({32'b0, cut_sq} << 16)) return r;
    if (r2 == 64'd0) r2 = 64'd1;
    idx = {p.ki, p.kj};
    s2 = 64'(sig_tab[16*idx +: 16]);
    eps = 64'(eps_tab[16*idx +: 16]);
    sr2 = (s2 << 48) / r2;
    sr4 = shr_prod(sr2, sr2, 24, hit);
    sr6 = shr_prod(sr4, sr2, 24, hit);
    // Energy: eps * sr6 * (sr6 - 1).
    neg = sr6 < ONE_Q24;
    mag = neg ? ONE_Q24 - sr6 : sr6 - ONE_Q24;
    mag = shr_prod(sr6, mag, 24, hit);
    mag = shr_prod(mag, eps, 8, hit);
    r.energy = to_q48(mag, neg && mag != 0, hit);
    // Force: 48 * eps * sr6 * (0.5 - sr6) / r2 times each difference.
    neg = sr6 > HALF_Q24;
    mag = neg ? sr6 - HALF_Q24 : HALF_Q24 - sr6;
    m = shr_prod(sr6, mag, 24, hit);
    inv_r2 = INV_NUM / r2;
    w = shr_prod(m, inv_r2, 24, hit);
    g = shr_prod(w, eps * 64'd48, 8, hit);
    f = shr_prod(g, ad[0], 16, hit);
    r.gx = to_q48(f, (neg != (d[0] < 0)) && f != 0, hit);
    f = shr_prod(g, ad[1], 16, hit);
    r.gy = to_q48(f, (neg != (d[1] < 0)) && f != 0, hit);
    f = shr_prod(g, ad[2], 16, hit);
    r.gz = to_q48(f, (neg != (d[2] < 0)) && f != 0, hit);
    r.in_range = 1'b1;
    r.clipped = hit;
    return r;
  endfunction

  // Field check with a report on mismatch.
  task automatic check_field(input string name, input logic [47:0] exp_v,
                             input logic [47:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  // Result monitor: every strobe is compared with the oldest expectation.
  always @(posedge clk) begin
    lj_result_t e;
    if (rst_n && out_valid) begin
      if (force_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, out_pair_energy);
        fails++;
      end else begin
        e = force_q.pop_front();
        check_field("grad_x", e.gx, out_grad_x);
        check_field("grad_y", e.gy, out_grad_y);
        check_field("grad_z", e.gz, out_grad_z);
        check_field("pair_energy", e.energy, out_pair_energy);
        check_field("within_cutoff", 48'(e.in_range), 48'(out_within_cutoff));
        check_field("saturated", 48'(e.clipped), 48'(out_saturated));
      end
    end
  end

  // Register write, mirrored into the shadow copy.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_BOX_X:     box_len[0] = val[23:0];
      CFG_BOX_Y:     box_len[1] = val[23:0];
      CFG_BOX_Z:     box_len[2] = val[23:0];
      CFG_INV_HALF:  inv_half = val[59:0];
      CFG_CUTOFF_SQ: cut_sq = val[31:0];
      CFG_SIGMA_SQ:  sig_tab = val;
      CFG_EPSILON:   eps_tab = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Periodic box with matching 2/L terms, then cutoff and pair tables.
  task automatic set_box(input logic [23:0] lx, input logic [23:0] ly, input logic [23:0] lz,
                         input logic [31:0] cut, input logic [63:0] sig, input logic [63:0] eps);
    logic [59:0] inv;
    inv[19:0] = lx == 0 ? 20'd0 : 20'((64'd1 << 37) / lx);
    inv[39:20] = ly == 0 ? 20'd0 : 20'((64'd1 << 37) / ly);
    inv[59:40] = lz == 0 ? 20'd0 : 20'((64'd1 << 37) / lz);
    write_reg(CFG_BOX_X, 64'(lx));
    write_reg(CFG_BOX_Y, 64'(ly));
    write_reg(CFG_BOX_Z, 64'(lz));
    write_reg(CFG_INV_HALF, 64'(inv));
    write_reg(CFG_CUTOFF_SQ, 64'(cut));
    write_reg(CFG_SIGMA_SQ, sig);
    write_reg(CFG_EPSILON, eps);
  endtask

  // Issue one pair transaction, record its expectation, then maybe idle.
  task automatic send_pair(input pair_t p, input logic has_typed, input lj_result_t typed);
    int gap, roll;
    start <= 1'b1;
    {in_pos_ix, in_pos_iy, in_pos_iz, in_pos_jx, in_pos_jy, in_pos_jz,
     in_kind_i, in_kind_j, in_same_particle} <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    force_q.push_back(has_typed ? typed : predict_pair(p));
    roll = $urandom_range(0, 99);
    gap = roll < 60 ? 0 : (roll < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until every outstanding result has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (force_q.size() != 0) @(posedge clk);
  endtask

  // Near-neighbor coordinate inside the periodic span of one axis.
  function automatic logic [23:0] near_coord(input logic [23:0] base, input logic [23:0] span_reg,
                                             input int reach);
    int span, v;
    span = span_reg == 0 ? (1 << 24) : int'(span_reg);
    v = int'(base) + $urandom_range(0, 2 * reach) - reach;
    if (v < 0) v += span;
    if (v >= span) v -= span;
    return 24'(v);
  endfunction

  // Random pairs: mostly close neighbors in the box, the rest unrestricted.
  task automatic random_pairs(input int count, input int reach);
    pair_t p;
    int span;
    for (int n = 0; n < count; n++) begin
      p = pair_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
      if ($urandom_range(0, 99) < 80) begin
        span = box_len[0] == 0 ? (1 << 24) : int'(box_len[0]);
        p.ix = 24'($urandom_range(0, span - 1));
        span = box_len[1] == 0 ? (1 << 24) : int'(box_len[1]);
        p.iy = 24'($urandom_range(0, span - 1));
        span = box_len[2] == 0 ? (1 << 24) : int'(box_len[2]);
        p.iz = 24'($urandom_range(0, span - 1));
        p.jx = near_coord(p.ix, box_len[0], reach);
        p.jy = near_coord(p.iy, box_len[1], reach);
        p.jz = near_coord(p.iz, box_len[2], reach);
      end
      p.same = $urandom_range(0, 99) < 5;
      send_pair(p, 1'b0, '0);
    end
  endtask

  // Directed rows: the first two run right after reset, the rest under a
  // ten-unit box with a 2.5 cutoff.
  initial begin
    pair_t p;
    p = '0;
    dir_tab.push_back('{p, 1'b1, '0});
    p = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h0, 24'h0, 24'h0, 1'b1, 1'b1, 1'b0};
    dir_tab.push_back('{p, 1'b1, '0});
    // Same particle gives all zeros.
    p = '{24'h010000, 24'h010000, 24'h010000, 24'h018000, 24'h010000, 24'h010000,
          1'b0, 1'b0, 1'b1};
    dir_tab.push_back('{p, 1'b1, '0});
    // Exactly at the cutoff counts as outside.
    p = '{24'h050000, 24'h010000, 24'h010000, 24'h028000, 24'h010000, 24'h010000,
          1'b0, 1'b1, 1'b0};
    dir_tab.push_back('{p, 1'b1, '0});
    // Coincident particles.
    p = '{24'h030000, 24'h030000, 24'h030000, 24'h030000, 24'h030000, 24'h030000,
          1'b0, 1'b0, 1'b0};
    dir_tab.push_back('{p, 1'b0, '0});
    // Unit distance for every species combination.
    for (int c = 0; c < 4; c++) begin
      p = '{24'h020000, 24'h020000, 24'h020000, 24'h030000, 24'h020000, 24'h020000,
            c[1], c[0], 1'b0};
      dir_tab.push_back('{p, 1'b0, '0});
    end
    // Very close pair, strongly repulsive and clipped.
    p = '{24'h020000, 24'h020000, 24'h020000, 24'h020010, 24'h020008, 24'h020000,
          1'b1, 1'b0, 1'b0};
    dir_tab.push_back('{p, 1'b0, '0});
    // Attractive range, negative differences on all axes.
    p = '{24'h020000, 24'h020000, 24'h020000, 24'h031000, 24'h030000, 24'h028000,
          1'b0, 1'b1, 1'b0};
    dir_tab.push_back('{p, 1'b0, '0});
    // Neighbors across the periodic boundary.
    p = '{24'h000800, 24'h09F000, 24'h000000, 24'h09F800, 24'h001000, 24'h09C000,
          1'b1, 1'b1, 1'b0};
    dir_tab.push_back('{p, 1'b0, '0});
    // Coordinate extremes, far apart before wrapping.
    p = '{24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
          1'b0, 1'b0, 1'b0};
    dir_tab.push_back('{p, 1'b0, '0});
  end

  // Main stimulus sequence.
  initial begin
    box_len = '{24'd0, 24'd0, 24'd0};
    inv_half = '0;
    cut_sq = '0;
    sig_tab = '0;
    eps_tab = '0;
    fails = 0;
    rst_n = 1'b0;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_BOX_X;
    cfg_wdata = '0;
    {in_pos_ix, in_pos_iy, in_pos_iz, in_pos_jx, in_pos_jy, in_pos_jz} = '0;
    {in_kind_i, in_kind_j, in_same_particle} = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: nothing is inside a zero cutoff.
    for (int n = 0; n < 2; n++) send_pair(dir_tab[n].pair, dir_tab[n].has_typed, dir_tab[n].typed);
    drain();

    // Ten-unit cube, cutoff 2.5, distinct pair tables.
    set_box(24'h0A0000, 24'h0A0000, 24'h0A0000, 32'h0006_4000,
            64'h00CD_0100_0100_0133, 64'h0200_0080_0080_0100);
    for (int n = 2; n < dir_tab.size(); n++)
      send_pair(dir_tab[n].pair, dir_tab[n].has_typed, dir_tab[n].typed);
    random_pairs(230, 3 << 16);
    drain();

    // Every register at its maximum, plus a write to an unused index.
    write_reg(CFG_BOX_X, '1);
    write_reg(CFG_BOX_Y, '1);
    write_reg(CFG_BOX_Z, '1);
    write_reg(CFG_INV_HALF, '1);
    write_reg(CFG_CUTOFF_SQ, '1);
    write_reg(CFG_SIGMA_SQ, '1);
    write_reg(CFG_EPSILON, '1);
    write_reg(CFG_SPARE, 64'h0123_4567_89AB_CDEF);
    random_pairs(230, 1 << 20);
    drain();

    // No wrapping at all, wide cutoff, random tables.
    set_box(24'd0, 24'd0, 24'd0, 32'h0064_0000, {$urandom, $urandom}, {$urandom, $urandom});
    random_pairs(230, 8 << 16);
    drain();

    // Fully random register contents.
    for (int r = 0; r <= int'(CFG_EPSILON); r++) write_reg(3'(r), {$urandom, $urandom});
    random_pairs(230, 1 << 23);
    drain();

    // Small box, some zero table entries.
    set_box(24'h040000, 24'h040000, 24'h040000, 32'h0004_0000,
            64'h0000_0040_0080_0100, 64'h0100_0000_FFFF_0040);
    random_pairs(230, 2 << 16);
    drain();

    // Uneven box, tight sigma.
    set_box(24'h080000, 24'h0C0000, 24'h100000, 32'h0009_0000,
            64'h0190_0100_0100_0080, 64'h0010_0200_0200_0400);
    random_pairs(230, 3 << 16);
    drain();

    repeat (100) @(posedge clk);
    if (fails == 0) $display("tb_lj_pair_force_energy OK");
    else $display("tb_lj_pair_force_energy NOT OK");
    $finish;
  end

endmodule

[lj_pair_force_energy.f]
+incdir+rtl
rtl/ljpf_pkg.sv
rtl/lj_pair_force_energy.sv
verif/tb_lj_pair_force_energy.sv
